@@ rtl/sla_pkg.sv @@
// sla_pkg: shared types, constants and helpers for the advection block
// no dependencies
`timescale 1ns / 1ps
package sla_pkg;
   localparam int MaxN = 126;
   localparam int GridSide = 128;
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_ADVECT = 1'b1;
   localparam logic [0:0] CSR_GRID_SIZE = 1'b0;
   localparam logic [0:0] CSR_TIME_STEP = 1'b1;
   localparam logic [6:0] GRID_SIZE_RESET = 7'd126;
   localparam logic [23:0] TIME_STEP_RESET = 24'd655;

   typedef struct packed {
      logic        op;
      logic [6:0]  cell_x;
      logic [6:0]  cell_y;
      logic signed [31:0] source_value;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_value;
      logic        out_of_range;
   } rsp_type;

   // truncating unsigned q1.16 x signed multiply, rounding toward zero
   function automatic logic signed [48:0] mul_frac(input logic [16:0] f,
                                                   input logic signed [48:0] v);
      logic signed [66:0] p;
      logic signed [66:0] q;
      begin
         p = $signed({1'b0, f}) * v;
         q = p[66] ? p + 67'sd65535 : p;
         mul_frac = q[64:16];
      end
   endfunction
endpackage

@@ rtl/sla_if.sv @@
// sla_if: valid/ready channel carrying one payload
// depends on sla_pkg for payload types
`timescale 1ns / 1ps
interface sla_req_if;
   import sla_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sla_rsp_if;
   import sla_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/sla_bank.sv @@
// sla_bank: one parity bank of the source grid, 64x64 words
// depends on sla_pkg
`timescale 1ns / 1ps
module sla_bank import sla_pkg::*; (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [11:0] wr_addr,
   input  logic [31:0] wr_data,
   input  logic        rd_en,
   input  logic [11:0] rd_addr,
   output logic [31:0] rd_data
);
   logic [31:0] mem [0:4095];
   // synchronous write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/semi_lagrangian_advect.sv @@
// semi_lagrangian_advect: top level of the grid advection step
// depends on sla_pkg, sla_if, sla_bank
//
// channel | dir | payload
// req     | in  | op, cell_x, cell_y, source_value, vel_x, vel_y
// rsp     | out | out_value, out_of_range
// csr     | in  | index 0 grid_size, index 1 time_step
//
// one item per cycle unless stalled; advect results leave from out_ff.
// the grid lives in four parity banks, so the four corners read in the same cycle.
// an advect right after a load of a neighbor sees its write by pipeline order:
// reads happen in stage 2, writes at stage 2 too, in transfer order.
// reset is synchronous, clears control only; the grid is undefined until loaded.
// the whole pipe stalls when the output register is full and not taken.
`timescale 1ns / 1ps
module semi_lagrangian_advect import sla_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   sla_req_if.sink     req,
   sla_rsp_if.source   rsp,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [23:0] csr_data
);
   logic [6:0]  grid_size_ff;
   logic [23:0] time_step_ff;
   logic        adv;
   logic [6:0]  n_eff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= GRID_SIZE_RESET;
         time_step_ff <= TIME_STEP_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_GRID_SIZE: grid_size_ff <= csr_data[6:0];
            CSR_TIME_STEP: time_step_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      n_eff = grid_size_ff;
      if (n_eff == 7'd0) n_eff = 7'd1;
      if (n_eff > 7'(MaxN)) n_eff = 7'(MaxN);
   end

   // pipe control: stages 1..5, output register
   logic [5:1] v_ff;
   logic       out_v_ff;
   rsp_type    out_ff;
   logic       adv_en;
   logic       out_live_ff;
   assign adv_en = !out_live_ff || rsp.ready;
   assign req.ready = adv_en;
   assign adv = req.valid && adv_en;

   // stage 1: dt*N and range check
   logic        s1_op_ff, s1_oor_ff;
   logic [6:0]  s1_x_ff, s1_y_ff;
   logic [31:0] s1_wd_ff;
   logic signed [31:0] s1_u_ff, s1_v_ff;
   logic [30:0] s1_dt0_ff;
   // stage 2: displacement products
   logic        s2_op_ff, s2_oor_ff;
   logic [6:0]  s2_x_ff, s2_y_ff;
   logic [31:0] s2_wd_ff;
   logic signed [63:0] s2_px_ff, s2_py_ff;
   // stage 3: clamp, split, memory read
   logic        s3_oor_ff;
   logic [16:0] s3_s1_ff, s3_t1_ff;
   logic        s3_xo_ff, s3_yo_ff;
   // stage 4: column blends
   logic        s4_oor_ff;
   logic [16:0] s4_s1_ff;
   logic signed [48:0] s4_l_ff, s4_r_ff;
   // stage 5: final blend
   logic        s5_oor_ff;
   logic signed [49:0] s5_r_ff;

   logic [30:0] dt0_in;
   assign dt0_in = 31'(time_step_ff) * 31'(n_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         out_v_ff <= 1'b0;
      end else if (adv_en) begin
         v_ff <= {v_ff[4:1], adv};
         out_v_ff <= v_ff[5];
      end else if (rsp.ready) begin
         out_v_ff <= 1'b0;
      end
   end

   // trace-back position helpers
   logic signed [49:0] pos_x, pos_y, pdx, pdy;
   logic signed [49:0] hi_q;
   logic signed [49:0] cx, cy;
   always_comb begin
      pdx = s2_px_ff[63] ? 50'(($signed(s2_px_ff) + 64'sd65535) >>> 16)
                         : 50'(s2_px_ff >>> 16);
      pdy = s2_py_ff[63] ? 50'(($signed(s2_py_ff) + 64'sd65535) >>> 16)
                         : 50'(s2_py_ff >>> 16);
      pos_x = $signed({27'd0, s2_x_ff, 16'd0}) - pdx;
      pos_y = $signed({27'd0, s2_y_ff, 16'd0}) - pdy;
      hi_q = $signed({27'd0, n_eff, 16'h8000});
      cx = pos_x < 50'sd32768 ? 50'sd32768 : (pos_x > hi_q ? hi_q : pos_x);
      cy = pos_y < 50'sd32768 ? 50'sd32768 : (pos_y > hi_q ? hi_q : pos_y);
   end

   // bank addressing: corner i0/i0+1 by parity of x, same for y
   logic [6:0] i0, j0, i1, j1;
   logic [6:0] xe, xo, ye, yo;
   assign i0 = cx[22:16];
   assign j0 = cy[22:16];
   assign i1 = i0 + 7'd1;
   assign j1 = j0 + 7'd1;
   assign xe = i0[0] ? i1 : i0;
   assign xo = i0[0] ? i0 : i1;
   assign ye = j0[0] ? j1 : j0;
   assign yo = j0[0] ? j0 : j1;

   logic [31:0] rd [4];
   logic        rd_en;
   assign rd_en = adv_en && v_ff[2] && s2_op_ff && !s2_oor_ff;
   genvar b;
   generate
      for (b = 0; b < 4; b++) begin : g_bank
         localparam logic [1:0] BankId = 2'(b);
         logic wr_en;
         assign wr_en = adv_en && v_ff[2] && !s2_op_ff &&
                        s2_x_ff[0] == BankId[0] && s2_y_ff[0] == BankId[1];
         sla_bank u_bank (
            .clock  (clock),
            .wr_en  (wr_en),
            .wr_addr({s2_x_ff[6:1], s2_y_ff[6:1]}),
            .wr_data(s2_wd_ff),
            .rd_en  (rd_en),
            .rd_addr({(BankId[0] ? xo[6:1] : xe[6:1]), (BankId[1] ? yo[6:1] : ye[6:1])}),
            .rd_data(rd[b])
         );
      end
   endgenerate

   // pick corners back from parity banks
   logic signed [48:0] ca, cb, cc, cd;
   always_comb begin
      ca = 49'(signed'(rd[{s3_yo_ff, s3_xo_ff}]));
      cb = 49'(signed'(rd[{!s3_yo_ff, s3_xo_ff}]));
      cc = 49'(signed'(rd[{s3_yo_ff, !s3_xo_ff}]));
      cd = 49'(signed'(rd[{!s3_yo_ff, !s3_xo_ff}]));
   end

   logic signed [49:0] fin;
   assign fin = 50'(mul_frac(17'h10000 - s4_s1_ff, s4_l_ff))
              + 50'(mul_frac(s4_s1_ff, s4_r_ff));

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv_en) begin
         s1_op_ff <= req.data.op;
         s1_x_ff <= req.data.cell_x;
         s1_y_ff <= req.data.cell_y;
         s1_wd_ff <= req.data.source_value;
         s1_u_ff <= req.data.vel_x;
         s1_v_ff <= req.data.vel_y;
         s1_dt0_ff <= dt0_in;
         s1_oor_ff <= req.data.cell_x < 7'd1 || req.data.cell_x > n_eff ||
                      req.data.cell_y < 7'd1 || req.data.cell_y > n_eff;
         s2_op_ff <= s1_op_ff;
         s2_oor_ff <= s1_oor_ff;
         s2_x_ff <= s1_x_ff;
         s2_y_ff <= s1_y_ff;
         s2_wd_ff <= s1_wd_ff;
         s2_px_ff <= $signed({1'b0, s1_dt0_ff}) * s1_u_ff;
         s2_py_ff <= $signed({1'b0, s1_dt0_ff}) * s1_v_ff;
         s3_oor_ff <= s2_oor_ff;
         s3_s1_ff <= {1'b0, cx[15:0]};
         s3_t1_ff <= {1'b0, cy[15:0]};
         s3_xo_ff <= i0[0];
         s3_yo_ff <= j0[0];
         s4_oor_ff <= s3_oor_ff;
         s4_s1_ff <= s3_s1_ff;
         s4_l_ff <= mul_frac(17'h10000 - s3_t1_ff, ca) + mul_frac(s3_t1_ff, cb);
         s4_r_ff <= mul_frac(17'h10000 - s3_t1_ff, cc) + mul_frac(s3_t1_ff, cd);
         s5_oor_ff <= s4_oor_ff;
         s5_r_ff <= fin;
         out_ff.out_of_range <= s5_oor_ff;
         if (s5_oor_ff) out_ff.out_value <= '0;
         else if (s5_r_ff > 50'sd2147483647) out_ff.out_value <= 32'h7fffffff;
         else if (s5_r_ff < -50'sd2147483648) out_ff.out_value <= 32'h80000000;
         else out_ff.out_value <= s5_r_ff[31:0];
      end
   end

   // a load drops out of the pipe after stage 2
   logic [5:1] keep;
   assign keep = v_ff;
   logic s3_adv_ff, s4_adv_ff, s5_adv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_adv_ff <= 1'b0; s4_adv_ff <= 1'b0; s5_adv_ff <= 1'b0;
      end else if (adv_en) begin
         s3_adv_ff <= keep[2] && s2_op_ff;
         s4_adv_ff <= s3_adv_ff;
         s5_adv_ff <= s4_adv_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) out_live_ff <= 1'b0;
      else if (adv_en) out_live_ff <= s5_adv_ff;
      else if (rsp.ready) out_live_ff <= 1'b0;
   end

   assign rsp.valid = out_live_ff;
   assign rsp.data = out_ff;

   // checks
   a_live_sub: assert property (@(posedge clock) disable iff (reset)
      out_live_ff |-> out_v_ff) else $error("result without pipe slot");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> $stable(out_ff)) else $error("result changed");
   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !req.ready) else $error("accept while full");
endmodule
